// ----- hw/rtl/tmt_pkg.sv -----
// Shared types and constants for the TinyMT32 generator.
package tmt_pkg;

	localparam logic [31:0] TOP_MASK   = 32'h7fff_ffff;
	localparam logic [31:0] SEED_MULT  = 32'd1812433253;
	localparam logic [31:0] MAT1_RESET = 32'h8f70_11ee;
	localparam logic [31:0] MAT2_RESET = 32'hfc78_ff1f;
	localparam logic [31:0] TMAT_RESET = 32'h3793_fdff;

	// Period fix pattern, ASCII 'T','I','N','Y'
	localparam logic [31:0] FIX_WORD0 = 32'h0000_0054;
	localparam logic [31:0] FIX_WORD1 = 32'h0000_0049;
	localparam logic [31:0] FIX_WORD2 = 32'h0000_004e;
	localparam logic [31:0] FIX_WORD3 = 32'h0000_0059;

	localparam logic [2:0] MIX_LAST    = 3'd7;
	localparam logic [2:0] WARMUP_LAST = 3'd7;

	typedef enum logic [1:0] {
		CMD_SEED = 2'd0,
		CMD_STEP = 2'd1,
		CMD_GEN  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MAT1 = 2'd0,
		REG_MAT2 = 2'd1,
		REG_TMAT = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] seed_value;
	} req_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic [31:0] state_word0;
		logic [31:0] state_word1;
		logic [31:0] state_word2;
		logic [31:0] state_word3;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [31:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} state_t;

	typedef struct packed {
		logic [31:0] mat1;
		logic [31:0] mat2;
		logic [31:0] tmat;
	} mask_t;

endpackage

// ----- hw/rtl/tmt_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transaction.
interface tmt_stream_if #(
	parameter type payload_t = logic
) (
	input logic clk
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tmt_advance_unit.sv -----
// One TinyMT32 state transition plus tempering of the new state.
module tmt_advance_unit (
	input  tmt_pkg::state_t cur,
	input  tmt_pkg::mask_t  masks,
	output tmt_pkg::state_t nxt,
	output logic [31:0]     word
);
	logic [31:0] x;
	logic [31:0] y;
	logic [31:0] t1;

	always_comb begin
		x = (cur.w0 & tmt_pkg::TOP_MASK) ^ cur.w1 ^ cur.w2;
		x = x ^ (x << 1);
		y = cur.w3 ^ (cur.w3 >> 1) ^ x;
		nxt.w0 = cur.w1;
		nxt.w1 = cur.w2 ^ (y[0] ? masks.mat1 : 32'd0);
		nxt.w2 = x ^ (y << 10) ^ (y[0] ? masks.mat2 : 32'd0);
		nxt.w3 = y;
		t1 = nxt.w0 + (nxt.w2 >> 8);
		word = nxt.w3 ^ t1 ^ (t1[0] ? masks.tmat : 32'd0);
	end
endmodule

// ----- hw/rtl/tinymt32_generator_unit.sv -----
// Top level of the TinyMT32 generator: sequencer, state, config and output register.
//
// Channels: req carries a command and a seed, rsp returns one result per
// transaction (tempered word, zero unless generate, and the four state words
// after the command), cfg writes mat1, mat2 and tmat by index; cfg is always
// ready and writes to index three are dropped.
// Step and generate run one pass through the shared advance unit: the advance
// state registers the result and returns to idle, or waits in the done state
// while the output register is full. The no-op command goes to the done state.
// Seed runs seven mix rounds on the shared 32x32 multiplier (multiply, then
// add/xor and word rotate), then the period fix, and eight passes through the
// advance unit.
// req is ready only while the sequencer is idle; a new item is taken while a
// finished result still waits in the output register. If the receiver stalls
// and the register is still full when the next result is done, the sequencer
// holds that result until rsp drains.
// Reset clears the state words to zero, loads the standard mask values and
// empties the output register. Unseeded use advances the all-zero state.
module tinymt32_generator_unit (
	input  logic          clk,
	input  logic          arst_n,
	tmt_stream_if.sink    req,
	tmt_stream_if.source  rsp,
	tmt_stream_if.sink    cfg
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_FIX,
		S_ADV,
		S_DONE
	} seq_t;

	seq_t             st_q;
	tmt_pkg::state_t  gs_q;
	tmt_pkg::mask_t   masks_q;
	tmt_pkg::state_t  adv_nxt;
	tmt_pkg::state_t  fix_st;
	tmt_pkg::req_t    req_d;
	tmt_pkg::cfg_t    cfg_d;
	tmt_pkg::rsp_t    rsp_q;
	logic [31:0]      adv_word;
	logic [31:0]      mix_src;
	logic [31:0]      mul_q;
	logic [31:0]      word_q;
	logic [2:0]       cnt_q;
	logic             gen_q;
	logic             rsp_valid_q;
	logic             out_free;
	logic             rsp_load;
	logic             fix_zero;

	assign req_d     = req.data;
	assign cfg_d     = cfg.data;
	assign req.ready = (st_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp_load  = out_free && (((st_q == S_ADV) && (cnt_q == 3'd0)) || (st_q == S_DONE));
	assign mix_src   = gs_q.w0 ^ (gs_q.w0 >> 30);

	tmt_advance_unit u_adv (
		.cur   (gs_q),
		.masks (masks_q),
		.nxt   (adv_nxt),
		.word  (adv_word)
	);

	// After seven rotations the original word order sits one place over.
	always_comb begin
		fix_zero = (gs_q.w1[30:0] == 31'd0) && (gs_q.w2 == 32'd0) &&
			(gs_q.w3 == 32'd0) && (gs_q.w0 == 32'd0);
		if (fix_zero) begin
			fix_st.w0 = tmt_pkg::FIX_WORD0;
			fix_st.w1 = tmt_pkg::FIX_WORD1;
			fix_st.w2 = tmt_pkg::FIX_WORD2;
			fix_st.w3 = tmt_pkg::FIX_WORD3;
		end else begin
			fix_st.w0 = gs_q.w1;
			fix_st.w1 = gs_q.w2;
			fix_st.w2 = gs_q.w3;
			fix_st.w3 = gs_q.w0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			gs_q        <= '0;
			masks_q     <= '{mat1: tmt_pkg::MAT1_RESET, mat2: tmt_pkg::MAT2_RESET,
				tmat: tmt_pkg::TMAT_RESET};
			mul_q       <= '0;
			word_q      <= '0;
			cnt_q       <= '0;
			gen_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (tmt_pkg::reg_idx_t'(cfg_d.reg_index))
					tmt_pkg::REG_MAT1: masks_q.mat1 <= cfg_d.wdata;
					tmt_pkg::REG_MAT2: masks_q.mat2 <= cfg_d.wdata;
					tmt_pkg::REG_TMAT: masks_q.tmat <= cfg_d.wdata;
					default: ;
				endcase
			end

			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);

			unique case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						gen_q  <= (tmt_pkg::cmd_t'(req_d.command) == tmt_pkg::CMD_GEN);
						word_q <= '0;
						unique case (tmt_pkg::cmd_t'(req_d.command))
							tmt_pkg::CMD_SEED: begin
								gs_q  <= '{w0: req_d.seed_value, w1: masks_q.mat1,
									w2: masks_q.mat2, w3: masks_q.tmat};
								cnt_q <= 3'd1;
								st_q  <= S_MUL;
							end
							tmt_pkg::CMD_STEP: begin
								cnt_q <= '0;
								st_q  <= S_ADV;
							end
							tmt_pkg::CMD_GEN: begin
								cnt_q <= '0;
								st_q  <= S_ADV;
							end
							tmt_pkg::CMD_NOP: begin
								st_q <= S_DONE;
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_MUL: begin
					mul_q <= tmt_pkg::SEED_MULT * mix_src;
					st_q  <= S_ADD;
				end
				S_ADD: begin
					// Target word moves to the front and becomes the next round's source.
					gs_q.w0 <= gs_q.w1 ^ ({29'd0, cnt_q} + mul_q);
					gs_q.w1 <= gs_q.w2;
					gs_q.w2 <= gs_q.w3;
					gs_q.w3 <= gs_q.w0;
					if (cnt_q == tmt_pkg::MIX_LAST) begin
						st_q <= S_FIX;
					end else begin
						cnt_q <= cnt_q + 3'd1;
						st_q  <= S_MUL;
					end
				end
				S_FIX: begin
					gs_q  <= fix_st;
					cnt_q <= tmt_pkg::WARMUP_LAST;
					st_q  <= S_ADV;
				end
				S_ADV: begin
					gs_q <= adv_nxt;
					if (cnt_q != 3'd0) begin
						cnt_q <= cnt_q - 3'd1;
					end else begin
						word_q <= gen_q ? adv_word : 32'd0;
						if (out_free) begin
							rsp_q <= '{random_word: gen_q ? adv_word : 32'd0,
								state_word0: adv_nxt.w0, state_word1: adv_nxt.w1,
								state_word2: adv_nxt.w2, state_word3: adv_nxt.w3};
							st_q <= S_IDLE;
						end else begin
							st_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q <= '{random_word: word_q, state_word0: gs_q.w0,
							state_word1: gs_q.w1, state_word2: gs_q.w2,
							state_word3: gs_q.w3};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer leaves idle on every accepted command.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("req still ready after accepting a command");

	// Mix round counter runs from one to seven.
	a_mix_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_ADD) |-> (cnt_q != 3'd0))
		else $error("mix round counter out of range");

	// Period fix leaves a nonzero state and starts the full warm-up.
	a_fix_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIX) |=> (st_q == S_ADV) && (cnt_q == tmt_pkg::WARMUP_LAST) &&
			!((gs_q.w0[30:0] == 31'd0) && (gs_q.w1 == 32'd0) &&
			(gs_q.w2 == 32'd0) && (gs_q.w3 == 32'd0)))
		else $error("period fix left an all-zero state");

endmodule

// ----- tb/sv/tb_tinymt32_generator_unit.sv -----
// Self-checking testbench for the TinyMT32 generator unit: directed and random commands.
`timescale 1ns / 100ps

module tb_tinymt32_generator_unit;

	localparam int LIMIT_CYCLES = 500000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;

	tmt_stream_if #(.payload_t(tmt_pkg::req_t)) req_if (clk);
	tmt_stream_if #(.payload_t(tmt_pkg::rsp_t)) rsp_if (clk);
	tmt_stream_if #(.payload_t(tmt_pkg::cfg_t)) cfg_if (clk);

	tinymt32_generator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source),
		.cfg    (cfg_if.sink)
	);

	tmt_pkg::req_t   commands_to_send[$];
	tmt_pkg::rsp_t   results_due[$];
	tmt_pkg::state_t gen_state;
	tmt_pkg::mask_t  gen_masks;
	bit              req_taken;
	int              error_count;
	int              sender_idle_pct;
	int              receiver_idle_pct;
	int              hold_asks;
	int              hold_seen;
	int              hold_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------- predictor ----------------

	function automatic logic [31:0] mix_term(logic [31:0] x);
		return tmt_pkg::SEED_MULT * (x ^ (x >> 30));
	endfunction

	function automatic tmt_pkg::state_t advanced(tmt_pkg::state_t s, tmt_pkg::mask_t m);
		logic [31:0]     x;
		logic [31:0]     y;
		tmt_pkg::state_t n;
		y = s.w3;
		x = (s.w0 & tmt_pkg::TOP_MASK) ^ s.w1 ^ s.w2;
		x ^= x << 1;
		y ^= (y >> 1) ^ x;
		n.w0 = s.w1;
		n.w1 = s.w2;
		n.w2 = x ^ (y << 10);
		n.w3 = y;
		if (y[0]) begin
			n.w1 ^= m.mat1;
			n.w2 ^= m.mat2;
		end
		return n;
	endfunction

	function automatic logic [31:0] tempered(tmt_pkg::state_t s, tmt_pkg::mask_t m);
		logic [31:0] sum;
		logic [31:0] t;
		sum = s.w0 + (s.w2 >> 8);
		t = s.w3 ^ sum;
		if (sum[0])
			t ^= m.tmat;
		return t;
	endfunction

	function automatic tmt_pkg::state_t seeded(logic [31:0] seed, tmt_pkg::mask_t m);
		logic [31:0]     w [4];
		tmt_pkg::state_t s;
		w[0] = seed;
		w[1] = m.mat1;
		w[2] = m.mat2;
		w[3] = m.tmat;
		for (int k = 1; k <= tmt_pkg::MIX_LAST; k++)
			w[k % 4] ^= 32'(k) + mix_term(w[(k - 1) % 4]);
		// all-zero period fix
		if ((w[0] & tmt_pkg::TOP_MASK) == 32'd0 && w[1] == 32'd0 && w[2] == 32'd0 &&
				w[3] == 32'd0)
			s = {tmt_pkg::FIX_WORD0, tmt_pkg::FIX_WORD1, tmt_pkg::FIX_WORD2,
				tmt_pkg::FIX_WORD3};
		else
			s = {w[0], w[1], w[2], w[3]};
		for (int k = 0; k <= tmt_pkg::WARMUP_LAST; k++)
			s = advanced(s, m);
		return s;
	endfunction

	function automatic tmt_pkg::rsp_t predict_result(tmt_pkg::req_t item);
		tmt_pkg::rsp_t r;
		r.random_word = '0;
		case (tmt_pkg::cmd_t'(item.command))
			tmt_pkg::CMD_SEED: gen_state = seeded(item.seed_value, gen_masks);
			tmt_pkg::CMD_STEP: gen_state = advanced(gen_state, gen_masks);
			tmt_pkg::CMD_GEN: begin
				gen_state = advanced(gen_state, gen_masks);
				r.random_word = tempered(gen_state, gen_masks);
			end
			default: ;
		endcase
		r.state_word0 = gen_state.w0;
		r.state_word1 = gen_state.w1;
		r.state_word2 = gen_state.w2;
		r.state_word3 = gen_state.w3;
		return r;
	endfunction

	// Masks and seed that drive the mixed state to all zero (word zero top bit optional).
	function automatic void zero_mix_setup(input logic top, output tmt_pkg::mask_t m,
			output logic [31:0] seed);
		logic [31:0] w0;
		logic [31:0] w1_early;
		w0       = {top, 31'd0};
		seed     = w0 ^ (32'd4 + mix_term(32'd7));
		w1_early = 32'd5 + mix_term(w0);
		m.mat1   = w1_early ^ (32'd1 + mix_term(seed));
		m.mat2   = 32'd6 ^ (32'd2 + mix_term(w1_early));
		m.tmat   = 32'd7 ^ (32'd3 + mix_term(32'd6));
	endfunction

	// ---------------- checking ----------------

	task automatic flag_error(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		req_taken <= req_if.valid && req_if.ready;
		if (cfg_if.valid && cfg_if.ready) begin
			case (tmt_pkg::reg_idx_t'(cfg_if.data.reg_index))
				tmt_pkg::REG_MAT1: gen_masks.mat1 = cfg_if.data.wdata;
				tmt_pkg::REG_MAT2: gen_masks.mat2 = cfg_if.data.wdata;
				tmt_pkg::REG_TMAT: gen_masks.tmat = cfg_if.data.wdata;
				default: ;
			endcase
		end
		if (req_if.valid && req_if.ready) begin
			results_due = {results_due, predict_result(req_if.data)};
			void'(commands_to_send.pop_front());
		end
		if (rsp_if.valid && rsp_if.ready) begin
			if (results_due.size() == 0) begin
				flag_error("unexpected result", rsp_if.data.random_word, '0);
			end else begin
				tmt_pkg::rsp_t want;
				want = results_due.pop_front();
				if (rsp_if.data.random_word !== want.random_word)
					flag_error("random_word", rsp_if.data.random_word, want.random_word);
				if (rsp_if.data.state_word0 !== want.state_word0)
					flag_error("state_word0", rsp_if.data.state_word0, want.state_word0);
				if (rsp_if.data.state_word1 !== want.state_word1)
					flag_error("state_word1", rsp_if.data.state_word1, want.state_word1);
				if (rsp_if.data.state_word2 !== want.state_word2)
					flag_error("state_word2", rsp_if.data.state_word2, want.state_word2);
				if (rsp_if.data.state_word3 !== want.state_word3)
					flag_error("state_word3", rsp_if.data.state_word3, want.state_word3);
			end
		end
	end

	// ---------------- driving ----------------

	// Command driver: keeps valid up until the transaction goes through.
	always @(negedge clk) begin
		if (!req_if.valid || req_taken) begin
			if (arst_n && commands_to_send.size() > 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				req_if.valid <= 1'b1;
				req_if.data  <= commands_to_send[0];
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls and an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= arst_n && ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// ---------------- sequence ----------------

	task automatic write_reg(tmt_pkg::reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{reg_index: idx, wdata: value};
		do
			@(posedge clk);
		while (!cfg_if.ready);
	endtask

	task automatic write_masks(tmt_pkg::mask_t m);
		write_reg(tmt_pkg::REG_MAT1, m.mat1);
		write_reg(tmt_pkg::REG_MAT2, m.mat2);
		write_reg(tmt_pkg::REG_TMAT, m.tmat);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send(tmt_pkg::cmd_t c, logic [31:0] seed);
		tmt_pkg::req_t item;
		item = '{command: c, seed_value: seed};
		commands_to_send = {commands_to_send, item};
	endtask

	task automatic wait_drained();
		while (commands_to_send.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic tmt_pkg::req_t random_command();
		tmt_pkg::req_t item;
		int unsigned   pick;
		pick = $urandom_range(99);
		if (pick < 10)
			item.command = tmt_pkg::CMD_SEED;
		else if (pick < 14)
			item.command = tmt_pkg::CMD_NOP;
		else if (pick < 45)
			item.command = tmt_pkg::CMD_STEP;
		else
			item.command = tmt_pkg::CMD_GEN;
		case ($urandom_range(15))
			0: item.seed_value = 32'd0;
			1: item.seed_value = 32'hffff_ffff;
			2: item.seed_value = 32'h8000_0000;
			3: item.seed_value = 32'h7fff_ffff;
			default: item.seed_value = $urandom;
		endcase
		return item;
	endfunction

	task automatic random_phase(int count, int snd_pct, int rcv_pct, bit with_hold);
		sender_idle_pct   = snd_pct;
		receiver_idle_pct = rcv_pct;
		for (int i = 0; i < count; i++)
			commands_to_send = {commands_to_send, random_command()};
		if (with_hold)
			hold_asks++;
		wait_drained();
	endtask

	initial begin
		tmt_pkg::mask_t m;
		logic [31:0]    fix_seed;

		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.data       = '0;
		rsp_if.ready      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.data       = '0;
		req_taken         = 1'b0;
		error_count       = 0;
		hold_asks         = 0;
		hold_seen         = 0;
		hold_left         = 0;
		sender_idle_pct   = 7;
		receiver_idle_pct = 49;
		gen_state         = '0;
		gen_masks         = '{mat1: tmt_pkg::MAT1_RESET, mat2: tmt_pkg::MAT2_RESET,
			tmat: tmt_pkg::TMAT_RESET};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unseeded use, then seeds at the field extremes, every command
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_STEP, 32'hffff_ffff);
		send(tmt_pkg::CMD_NOP, 32'h0);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_SEED, 32'h0);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_GEN, 32'hffff_ffff);
		send(tmt_pkg::CMD_STEP, 32'h0);
		send(tmt_pkg::CMD_NOP, 32'hffff_ffff);
		send(tmt_pkg::CMD_SEED, 32'hffff_ffff);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_STEP, 32'h0);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_SEED, 32'h8000_0000);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_SEED, 32'h7fff_ffff);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_SEED, 32'd1);
		send(tmt_pkg::CMD_GEN, 32'h0);
		send(tmt_pkg::CMD_NOP, 32'h0);
		send(tmt_pkg::CMD_GEN, 32'h0);
		wait_drained();

		// random masks, a write to the unused index, long receiver hold-off
		write_masks('{mat1: $urandom, mat2: $urandom, tmat: $urandom});
		write_reg(tmt_pkg::REG_NONE, $urandom);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		random_phase(400, 7, 49, 1'b1);

		write_masks('{mat1: '1, mat2: '1, tmat: '1});
		random_phase(100, 49, 7, 1'b0);

		// seeds whose mixed state is all zero trigger the period fix
		for (int top = 0; top < 2; top++) begin
			zero_mix_setup(top[0], m, fix_seed);
			write_masks(m);
			send(tmt_pkg::CMD_SEED, fix_seed);
			send(tmt_pkg::CMD_GEN, 32'h0);
			send(tmt_pkg::CMD_GEN, 32'h0);
			wait_drained();
		end

		write_masks('{mat1: '0, mat2: '0, tmat: '0});
		random_phase(100, 49, 7, 1'b0);

		write_masks('{mat1: tmt_pkg::MAT1_RESET, mat2: tmt_pkg::MAT2_RESET,
			tmat: tmt_pkg::MAT2_RESET ^ tmt_pkg::MAT1_RESET});
		random_phase(250, 49, 7, 1'b0);

		write_masks('{mat1: tmt_pkg::MAT1_RESET, mat2: tmt_pkg::MAT2_RESET,
			tmat: tmt_pkg::TMAT_RESET});
		random_phase(350, 0, 0, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tmt_pkg.sv
hw/rtl/tmt_stream_if.sv
hw/rtl/tmt_advance_unit.sv
hw/rtl/tinymt32_generator_unit.sv
tb/sv/tb_tinymt32_generator_unit.sv
